// ----- hdl/h2r_pkg.sv -----
`timescale 1ns / 1ps

package h2r_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned HUE_SPAN   = 43;  // hue codes per sector; the last sector, 215..255, has 41
    localparam int unsigned FRAC_SCALE = 6;   // stretches the in-sector offset to 0..252
    localparam int unsigned OFFSET_W   = 6;   // in-sector offset is 0..42

    typedef logic [CHAN_W-1:0] chan_t;

    // Hue sectors, named by the primary ramp they cover
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,  // red to yellow
        SEC_YG = 3'd1,  // yellow to green
        SEC_GC = 3'd2,  // green to cyan
        SEC_CB = 3'd3,  // cyan to blue
        SEC_BM = 3'd4,  // blue to magenta
        SEC_MR = 3'd5   // magenta to red
    } sector_t;

    // After hue split and p level
    typedef struct packed {
        sector_t sector;
        chan_t   frac;
        chan_t   sat;
        chan_t   bri;
        chan_t   p;
    } front_t;

    // After saturation scaling by frac and 255 - frac
    typedef struct packed {
        sector_t sector;
        chan_t   bri;
        chan_t   p;
        chan_t   sat_fall;
        chan_t   sat_rise;
    } sat_t;

    // All four levels ready for routing
    typedef struct packed {
        sector_t sector;
        chan_t   bri;
        chan_t   p;
        chan_t   q;
        chan_t   t;
    } level_t;

    // (x * (k + 1)) >> 8, exact for k = 255
    function automatic chan_t scale_by(input chan_t x, input chan_t k);
        logic [2*CHAN_W:0] prod;
        prod = {1'b0, x} * ({1'b0, k} + (CHAN_W+1)'(1));
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

// ----- hdl/h2r_front.sv -----
`timescale 1ns / 1ps

module h2r_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  h2r_pkg::chan_t   hue,
    input  h2r_pkg::chan_t   saturation,
    input  h2r_pkg::chan_t   brightness,
    output logic             out_valid,
    input  logic             out_ready,
    output h2r_pkg::front_t  out_data
);

    logic                          valid_reg;
    h2r_pkg::front_t               data_reg;
    h2r_pkg::front_t               data_next;
    h2r_pkg::sector_t              sector;
    h2r_pkg::chan_t                base;
    logic [h2r_pkg::OFFSET_W-1:0]  offset;

    // sector = hue / 43 by threshold compare
    always_comb
    begin
        if (hue >= h2r_pkg::CHAN_W'(5 * h2r_pkg::HUE_SPAN))
            sector = h2r_pkg::SEC_MR;
        else if (hue >= h2r_pkg::CHAN_W'(4 * h2r_pkg::HUE_SPAN))
            sector = h2r_pkg::SEC_BM;
        else if (hue >= h2r_pkg::CHAN_W'(3 * h2r_pkg::HUE_SPAN))
            sector = h2r_pkg::SEC_CB;
        else if (hue >= h2r_pkg::CHAN_W'(2 * h2r_pkg::HUE_SPAN))
            sector = h2r_pkg::SEC_GC;
        else if (hue >= h2r_pkg::CHAN_W'(h2r_pkg::HUE_SPAN))
            sector = h2r_pkg::SEC_YG;
        else
            sector = h2r_pkg::SEC_RY;
    end

    always_comb
    begin
        base   = h2r_pkg::CHAN_W'(32'(sector) * h2r_pkg::HUE_SPAN);
        offset = h2r_pkg::OFFSET_W'(hue - base);
        data_next.sector = sector;
        data_next.frac   = h2r_pkg::CHAN_W'(32'(offset) * h2r_pkg::FRAC_SCALE);
        data_next.sat    = saturation;
        data_next.bri    = brightness;
        data_next.p      = h2r_pkg::scale_by(brightness, ~saturation);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/h2r_levels.sv -----
`timescale 1ns / 1ps

module h2r_levels (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  h2r_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output h2r_pkg::level_t  out_data
);

    logic             sat_valid_reg;
    h2r_pkg::sat_t    sat_reg;
    h2r_pkg::sat_t    sat_next;
    logic             sat_ready;
    logic             lvl_valid_reg;
    h2r_pkg::level_t  lvl_reg;
    h2r_pkg::level_t  lvl_next;

    // stage A: s scaled by frac and by 255 - frac
    always_comb
    begin
        sat_next.sector   = in_data.sector;
        sat_next.bri      = in_data.bri;
        sat_next.p        = in_data.p;
        sat_next.sat_fall = h2r_pkg::scale_by(in_data.sat, in_data.frac);
        sat_next.sat_rise = h2r_pkg::scale_by(in_data.sat, ~in_data.frac);
    end

    // stage B: q and t from brightness
    always_comb
    begin
        lvl_next.sector = sat_reg.sector;
        lvl_next.bri    = sat_reg.bri;
        lvl_next.p      = sat_reg.p;
        lvl_next.q      = h2r_pkg::scale_by(sat_reg.bri, ~sat_reg.sat_fall);
        lvl_next.t      = h2r_pkg::scale_by(sat_reg.bri, ~sat_reg.sat_rise);
    end

    assign sat_ready = !lvl_valid_reg || out_ready;
    assign in_ready  = !sat_valid_reg || sat_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
            lvl_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sat_valid_reg <= in_valid;
            if (sat_ready)
                lvl_valid_reg <= sat_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sat_reg <= sat_next;
        if (sat_ready && sat_valid_reg)
            lvl_reg <= lvl_next;
    end

    assign out_valid = lvl_valid_reg;
    assign out_data  = lvl_reg;

endmodule

// ----- hdl/h2r_route.sv -----
`timescale 1ns / 1ps

module h2r_route (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  h2r_pkg::level_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output h2r_pkg::chan_t   red,
    output h2r_pkg::chan_t   green,
    output h2r_pkg::chan_t   blue
);

    logic            valid_reg;
    h2r_pkg::chan_t  red_reg;
    h2r_pkg::chan_t  green_reg;
    h2r_pkg::chan_t  blue_reg;
    h2r_pkg::chan_t  red_next;
    h2r_pkg::chan_t  green_next;
    h2r_pkg::chan_t  blue_next;

    always_comb
    begin
        case (in_data.sector)
            h2r_pkg::SEC_RY:
            begin
                red_next = in_data.bri; green_next = in_data.t;   blue_next = in_data.p;
            end
            h2r_pkg::SEC_YG:
            begin
                red_next = in_data.q;   green_next = in_data.bri; blue_next = in_data.p;
            end
            h2r_pkg::SEC_GC:
            begin
                red_next = in_data.p;   green_next = in_data.bri; blue_next = in_data.t;
            end
            h2r_pkg::SEC_CB:
            begin
                red_next = in_data.p;   green_next = in_data.q;   blue_next = in_data.bri;
            end
            h2r_pkg::SEC_BM:
            begin
                red_next = in_data.t;   green_next = in_data.p;   blue_next = in_data.bri;
            end
            default:
            begin
                red_next = in_data.bri; green_next = in_data.p;   blue_next = in_data.q;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ----- hdl/hsv_to_rgb_8bit.sv -----
`timescale 1ns / 1ps

// HSV to RGB converter, 8 bits per channel, six-sector scheme.
// Input channel: hue, saturation, brightness with in_valid / in_ready.
// Output channel: red, green, blue with out_valid / out_ready.
// A transaction moves on a channel when its valid and ready are both high.
// Pipeline: four register stages, at most one scaling multiply (8 x 9 bits) deep per stage:
//   1. hue split into sector and in-sector offset, p level
//   2. saturation scaled by the offset and by its complement
//   3. q and t levels from brightness
//   4. sector routing into the output registers
// Path: an accepted transaction passes the front, saturation, level and output
// registers in that order before it appears on the outputs.
// Throughput: one transaction per clock, sustained while the receiver does not stall.
// Each stage has its own valid bit and advances when it is empty or the stage
// after it advances, so a receiver stall fills bubbles first and then pushes
// back to in_ready; nothing is dropped or duplicated.
// Reset (rst_n low, asynchronous) empties all stages; out_valid drops at once.
// Zero saturation gives grey on its own: every level then equals brightness.
module hsv_to_rgb_8bit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  h2r_pkg::chan_t  hue,
    input  h2r_pkg::chan_t  saturation,
    input  h2r_pkg::chan_t  brightness,
    output logic            out_valid,
    input  logic            out_ready,
    output h2r_pkg::chan_t  red,
    output h2r_pkg::chan_t  green,
    output h2r_pkg::chan_t  blue
);

    // front stage to level stages
    logic             front_valid;
    logic             front_ready;
    h2r_pkg::front_t  front_data;

    // level stages to routing stage
    logic             level_valid;
    logic             level_ready;
    h2r_pkg::level_t  level_data;

    h2r_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    h2r_levels u_levels (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (front_valid),
        .in_ready   (front_ready),
        .in_data    (front_data),
        .out_valid  (level_valid),
        .out_ready  (level_ready),
        .out_data   (level_data)
    );

    h2r_route u_route (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (level_valid),
        .in_ready   (level_ready),
        .in_data    (level_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

// ----- test/hsv_checker.sv -----
`timescale 1ns / 1ps

module hsv_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  h2r_pkg::chan_t  hue,
    input  h2r_pkg::chan_t  saturation,
    input  h2r_pkg::chan_t  brightness,
    input  logic            out_valid,
    input  logic            out_ready,
    input  h2r_pkg::chan_t  red,
    input  h2r_pkg::chan_t  green,
    input  h2r_pkg::chan_t  blue,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        h2r_pkg::chan_t r;
        h2r_pkg::chan_t g;
        h2r_pkg::chan_t b;
    } rgb_t;

    rgb_t rgb_due[$];
    int   errors;

    assign fail_count = errors;

    // (x * (k + 1)) >> 8
    function automatic h2r_pkg::chan_t level_mul(input h2r_pkg::chan_t x,
                                                 input h2r_pkg::chan_t k);
        logic [16:0] prod;
        prod = 17'(x) * (17'(k) + 17'd1);
        return prod[15:8];
    endfunction

    function automatic rgb_t hsv_predict(input h2r_pkg::chan_t h,
                                         input h2r_pkg::chan_t s,
                                         input h2r_pkg::chan_t v);
        int             seg;
        h2r_pkg::chan_t offset;
        h2r_pkg::chan_t lvl_p;
        h2r_pkg::chan_t lvl_q;
        h2r_pkg::chan_t lvl_t;
        rgb_t           px;
        seg = int'(h) / int'(h2r_pkg::HUE_SPAN);
        offset = 8'((int'(h) - seg * int'(h2r_pkg::HUE_SPAN)) * int'(h2r_pkg::FRAC_SCALE));
        lvl_p = level_mul(v, 8'd255 - s);
        lvl_q = level_mul(v, 8'd255 - level_mul(s, offset));
        lvl_t = level_mul(v, 8'd255 - level_mul(s, 8'd255 - offset));
        if (s == 8'd0)
        begin
            px = '{v, v, v};
        end
        else
        begin
            case (h2r_pkg::sector_t'(seg[2:0]))
                h2r_pkg::SEC_RY: px = '{v, lvl_t, lvl_p};
                h2r_pkg::SEC_YG: px = '{lvl_q, v, lvl_p};
                h2r_pkg::SEC_GC: px = '{lvl_p, v, lvl_t};
                h2r_pkg::SEC_CB: px = '{lvl_p, lvl_q, v};
                h2r_pkg::SEC_BM: px = '{lvl_t, lvl_p, v};
                default:         px = '{v, lvl_p, lvl_q};
            endcase
        end
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        if (!rst_n)
        begin
            rgb_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                rgb_due.push_back(hsv_predict(hue, saturation, brightness));
            if (out_valid && out_ready)
            begin
                if (rgb_due.size() == 0)
                begin
                    $error("unexpected pixel: red %0d green %0d blue %0d", red, green, blue);
                    errors++;
                end
                else
                begin
                    want = rgb_due.pop_front();
                    if (red !== want.r)
                    begin
                        $error("red mismatch: expected %0d, got %0d", want.r, red);
                        errors++;
                    end
                    if (green !== want.g)
                    begin
                        $error("green mismatch: expected %0d, got %0d", want.g, green);
                        errors++;
                    end
                    if (blue !== want.b)
                    begin
                        $error("blue mismatch: expected %0d, got %0d", want.b, blue);
                        errors++;
                    end
                end
            end
            pending = rgb_due.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the HSV to RGB pipeline. Prediction and comparison
// live in hsv_checker, which watches both channels next to the DUT.
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int RAND_PER_PH  = 384;     // three phases, ~1150 random pixels
    localparam int HOLD_CYCLES  = 300;     // long output stall for back-pressure
    localparam int DRAIN_CYCLES = 20;      // pipeline is 4 deep

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    h2r_pkg::chan_t  hue;
    h2r_pkg::chan_t  saturation;
    h2r_pkg::chan_t  brightness;
    logic            out_valid;
    logic            out_ready;
    h2r_pkg::chan_t  red;
    h2r_pkg::chan_t  green;
    h2r_pkg::chan_t  blue;

    int fail_count;
    int pending;
    int cycle_count;
    int sent_count;
    int directed_count;

    // Pacing knobs, owned by the main process
    int tx_idle_pct;
    int rx_idle_pct;
    // Long-stall handshake between main process and receiver process:
    // main bumps hold_requests, receiver serves each one with a full stall.
    int hold_requests;
    int holds_served;
    int hold_left;

    hsv_to_rgb_8bit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hang or a lost pixel ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls at rx_idle_pct, plus long stalls on request.
    // Driven on the falling edge so the DUT sees a stable out_ready.
    initial
    begin
        out_ready    = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Random level with extra weight on the ends of the range
    function automatic h2r_pkg::chan_t pick_level();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random hue, a quarter of the time on a sector edge
    function automatic h2r_pkg::chan_t pick_hue();
        h2r_pkg::chan_t edges [12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                                       8'd129, 8'd171, 8'd172, 8'd214, 8'd215, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    // One transaction on the input channel. Entered and left on a falling edge;
    // valid stays high between back-to-back pixels, so it is never lowered and
    // raised in the same step.
    task automatic send_pixel(input h2r_pkg::chan_t h, input h2r_pkg::chan_t s,
                              input h2r_pkg::chan_t v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_pixel(pick_hue(), pick_level(), pick_level());
    endtask

    initial
    begin
        in_valid      = 1'b0;
        hue           = '0;
        saturation    = '0;
        brightness    = '0;
        rst_n         = 1'b0;
        tx_idle_pct   = 30;
        rx_idle_pct   = 65;
        hold_requests = 0;
        sent_count    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: range corners, grey, each sector start and end, dark pixels
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd128);   // grey, hue ignored
        send_pixel(8'd100, 8'd0,   8'd77);    // grey
        send_pixel(8'd0,   8'd0,   8'd255);   // white
        send_pixel(8'd42,  8'd255, 8'd255);
        send_pixel(8'd43,  8'd255, 8'd255);
        send_pixel(8'd85,  8'd255, 8'd255);
        send_pixel(8'd86,  8'd255, 8'd255);
        send_pixel(8'd128, 8'd255, 8'd255);
        send_pixel(8'd129, 8'd255, 8'd255);
        send_pixel(8'd171, 8'd255, 8'd255);
        send_pixel(8'd172, 8'd255, 8'd255);
        send_pixel(8'd214, 8'd255, 8'd255);
        send_pixel(8'd215, 8'd255, 8'd255);   // start of the last sector
        send_pixel(8'd240, 8'd200, 8'd180);
        send_pixel(8'd37,  8'd1,   8'd255);   // barely saturated
        send_pixel(8'd200, 8'd128, 8'd0);     // black with color
        send_pixel(8'd123, 8'd255, 8'd1);
        send_pixel(8'd60,  8'd254, 8'd254);
        send_pixel(8'd170, 8'd85,  8'd170);
        directed_count = sent_count;

        // Phase 1: slow receiver
        send_random(RAND_PER_PH);

        // Phase 2: slow sender
        tx_idle_pct = 65;
        rx_idle_pct = 30;
        send_random(RAND_PER_PH);

        // Phase 3: full rate, with one long output stall in the middle while
        // the sender keeps offering, so the stages fill and in_ready drops
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(RAND_PER_PH / 2);
        hold_requests++;
        send_random(RAND_PER_PH - RAND_PER_PH / 2);
        in_valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray pixel
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d pixels (%0d directed), sector edges, grey and level extremes",
                 sent_count, directed_count);
        $display("Summary: slow-receiver, slow-sender and full-rate pacing, %0d-cycle stall",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- hsv_to_rgb_8bit.f -----
hdl/h2r_pkg.sv
hdl/h2r_front.sv
hdl/h2r_levels.sv
hdl/h2r_route.sv
hdl/hsv_to_rgb_8bit.sv
test/hsv_checker.sv
test/tb_top.sv
